>>> src/rmsdb_pkg.sv
// Shared types and constants for the frame RMS / dBFS level meter.
`default_nettype none
package rmsdb_pkg;
  localparam int MAX_SAMPLES = 32768;
  localparam int SUM_W       = 62;
  localparam int CNT_W       = 16;
  localparam int PROD_W      = 47;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam logic signed [16:0] DB_SILENT = -17'sd24653;
  localparam logic [16:0]        DB_MIN_MAG = 17'd49152;
  localparam logic [17:0]        DB_SCALE   = 18'd197283;

  // one finished frame handed from the accumulator to the math engine
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } frame_t;
endpackage
`default_nettype wire

>>> src/rmsdb_front.sv
// Front end: accepts samples, squares them and accumulates per frame.
`default_nettype none
module rmsdb_front import rmsdb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_sample,
  input  wire logic               in_has_sample,
  input  wire logic               in_frame_last,
  output logic                    push,
  output frame_t                  push_data,
  input  wire logic               q_ready
);
  logic             s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0] s1_prod_r;
  logic             s1_last_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_ovf_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt, total;
  logic             accept, consume, add;
  logic [23:0]      mag;

  assign consume  = s1_valid_r && (!s1_last_r || q_ready);
  assign in_ready = !s1_valid_r || consume;
  assign accept   = in_valid && in_ready;
  assign add      = in_has_sample && (cnt_r < CNT_W'(MAX_SAMPLES));
  assign mag      = in_sample[23] ? 24'(-in_sample) : 24'(in_sample);
  assign total    = acc_r + SUM_W'(s1_prod_r);
  assign push     = consume && s1_last_r;
  assign push_data = '{sum: total, count: s1_cnt_r, ovf: s1_ovf_r};

  always_comb begin
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    s1_valid_nxt = consume ? 1'b0 : s1_valid_r;
    acc_nxt      = acc_r;
    if (consume) acc_nxt = s1_last_r ? '0 : total;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      cnt_nxt = in_frame_last ? '0 : cnt_r + CNT_W'(add);
      ovf_nxt = in_frame_last ? 1'b0 : (ovf_r | (in_has_sample & ~add));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      acc_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      acc_r      <= acc_nxt;
    end
    if (accept) begin
      s1_prod_r <= add ? PROD_W'(mag * mag) : '0;
      s1_last_r <= in_frame_last;
      s1_cnt_r  <= cnt_r + CNT_W'(add);
      s1_ovf_r  <= ovf_r | (in_has_sample & ~add);
    end
  end
endmodule
`default_nettype wire

>>> src/rmsdb_queue.sv
// Short frame queue between accumulator and math engine.
`default_nettype none
module rmsdb_queue import rmsdb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  frame_t      push_data,
  output logic        q_ready,
  output logic        q_valid,
  output frame_t      q_data,
  input  wire logic   pop
);
  frame_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     fill_r;

  assign q_ready = fill_r != (QPTR_W+1)'(QDEPTH);
  assign q_valid = fill_r != '0;
  assign q_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QPTR_W'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == QPTR_W'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      fill_r <= fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

>>> src/rmsdb_back.sv
// Back end: bitwise square root and iterative log2 level per frame.
`default_nettype none
module rmsdb_back import rmsdb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  frame_t           q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_rms_level,
  output logic signed [16:0] out_level_db,
  output logic [15:0]      out_sample_count,
  output logic             out_count_overflow
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQA = 4'd1, S_SQB = 4'd2, S_SQC = 4'd3,
                         S_NORM = 4'd4, S_LMUL = 4'd5, S_LSQ = 4'd6, S_DSUB = 4'd7,
                         S_DMUL = 4'd8, S_DFIN = 4'd9, S_OUT = 4'd10;

  logic [3:0]  st_r;
  frame_t      fr_r;
  logic [31:0] r_r;
  logic [4:0]  bit_r;
  logic [65:0] sq_r;
  logic [81:0] pr_r;
  logic [63:0] lv_r;
  logic [5:0]  le_r;
  logic [31:0] y_r;
  logic [63:0] yy_r;
  logic [3:0]  it_r;
  logic [15:0] frac_r;
  logic        which_r;
  logic [21:0] lgs_r, lgc_r;
  logic [21:0] mag_r;
  logic [39:0] dm_r;
  logic signed [16:0] db_r;
  logic        ov_r;

  logic [31:0] trial;
  logic [32:0] tt;
  logic [32:0] ysq;
  logic        fbit;
  logic [15:0] frac_new;
  logic signed [23:0] d;
  logic [16:0] q;
  logic        load;

  assign trial    = r_r | (32'd1 << bit_r);
  assign tt       = {trial, 1'b0} - 33'd1;
  assign ysq      = yy_r[63:31];
  assign fbit     = ysq[32];
  assign frac_new = {frac_r[14:0], fbit};
  assign d        = 24'(signed'({2'b0, lgs_r})) - 24'(signed'({2'b0, lgc_r}))
                    - 24'sd3014656;
  assign q        = 17'((dm_r + 40'd8388608) >> 24);
  assign pop      = (st_r == S_IDLE) && q_valid;
  assign load     = (st_r == S_OUT) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          fr_r  <= q_data;
          r_r   <= '0;
          bit_r <= 5'd31;
          db_r  <= DB_SILENT;
          st_r  <= (q_data.count == '0 || q_data.sum == '0) ? S_OUT : S_SQA;
        end
        S_SQA: begin
          sq_r <= tt * tt;
          st_r <= S_SQB;
        end
        S_SQB: begin
          pr_r <= sq_r * fr_r.count;
          st_r <= S_SQC;
        end
        S_SQC: begin
          if (pr_r <= {fr_r.sum, 18'd0}) r_r <= trial;
          if (bit_r == '0) begin
            lv_r    <= {2'b0, fr_r.sum};
            le_r    <= 6'd63;
            which_r <= 1'b0;
            st_r    <= S_NORM;
          end else begin
            bit_r <= bit_r - 1'b1;
            st_r  <= S_SQA;
          end
        end
        S_NORM: begin
          if (lv_r[63] || le_r == '0) begin
            y_r    <= lv_r[63:32];
            it_r   <= '0;
            frac_r <= '0;
            st_r   <= S_LMUL;
          end else begin
            lv_r <= {lv_r[62:0], 1'b0};
            le_r <= le_r - 1'b1;
          end
        end
        S_LMUL: begin
          yy_r <= y_r * y_r;
          st_r <= S_LSQ;
        end
        S_LSQ: begin
          y_r    <= fbit ? ysq[32:1] : ysq[31:0];
          frac_r <= frac_new;
          it_r   <= it_r + 1'b1;
          st_r   <= S_LMUL;
          if (it_r == 4'd15) begin
            if (!which_r) begin
              lgs_r   <= {le_r, frac_new};
              lv_r    <= {48'd0, fr_r.count};
              le_r    <= 6'd63;
              which_r <= 1'b1;
              st_r    <= S_NORM;
            end else begin
              lgc_r <= {le_r, frac_new};
              st_r  <= S_DSUB;
            end
          end
        end
        S_DSUB: begin
          if (!d[23]) begin
            db_r <= '0;
            st_r <= S_OUT;
          end else begin
            mag_r <= 22'(-d);
            st_r  <= S_DMUL;
          end
        end
        S_DMUL: begin
          dm_r <= mag_r * DB_SCALE;
          st_r <= S_DFIN;
        end
        S_DFIN: begin
          db_r <= (q > DB_MIN_MAG) ? -signed'(DB_MIN_MAG) : -signed'(q);
          st_r <= S_OUT;
        end
        S_OUT: if (load) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    if (load) begin
      out_rms_level      <= r_r;
      out_level_db       <= db_r;
      out_sample_count   <= fr_r.count;
      out_count_overflow <= fr_r.ovf;
    end
  end
endmodule
`default_nettype wire

>>> src/frame_rms_dbfs_meter_unit.sv
// Top level of the frame RMS / dBFS level meter.
// Samples: one transaction per cycle while in_ready is high; a frame end goes through
// the front multiply stage register before it reaches the queue. Per frame: a bitwise
// square root (one result bit per pass through S_SQA, S_SQB and S_SQC), two log2s
// (normalize, then 16 squarings each), and the dB scale in S_DSUB, S_DMUL, S_DFIN.
// Reset (rst_n low, synchronous) empties the queue and clears the sums.
`default_nettype none
module frame_rms_dbfs_meter_unit import rmsdb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_sample,
  input  wire logic               in_has_sample,
  input  wire logic               in_frame_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_rms_level,
  output logic signed [16:0]      out_level_db,
  output logic [15:0]             out_sample_count,
  output logic                    out_count_overflow
);
  // frame totals move front -> queue -> back, so the sample stream keeps
  // flowing while the previous frame's sqrt/log runs
  logic   push, q_ready, q_valid, pop;
  frame_t push_data, q_data;

  rmsdb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_has_sample,
    .in_frame_last, .push, .push_data, .q_ready
  );

  rmsdb_queue u_queue (
    .clk, .rst_n, .push, .push_data, .q_ready, .q_valid, .q_data, .pop
  );

  // back end holds its result in an output register until taken
  rmsdb_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .pop, .out_valid, .out_ready,
    .out_rms_level, .out_level_db, .out_sample_count, .out_count_overflow
  );
endmodule
`default_nettype wire
